@@ hdl/trle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the TGA run-length pixel encoder.
// ----------------------------------------------------------------------------
package trle_pkg;

  // Depths of the command queue and of the result queue
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // Packet header fields
  localparam logic [7:0] HDR_RUN_FLAG  = 8'h80;
  localparam logic [6:0] HDR_CNT_MASK  = 7'h7F;

  // One packet to emit, as handed from the front end to the back end
  typedef struct packed {
    logic        is_run;  // run packet: one pixel, count in header
    logic [7:0]  count;   // pixels in the packet
    logic        bank;    // buffer bank holding the raw pixels
    logic        last;    // packet closes the image
    logic [31:0] pixel;   // run pixel
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic        header_valid;
    logic [7:0]  header_byte;
    logic [31:0] pixel_out;
    logic        stream_last;
  } item_t;

  // Back end releases a drained buffer bank
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

endpackage

@@ hdl/tga_rle_pixel_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder
// TGA run-length encoder for 32-bit pixels.
//
// Input queue side: push_i with pixel_in_i and image_end_i is taken when
// full_o is low. Result queue side: while empty_o is low the oldest beat
// (header_valid_o, header_byte_o, pixel_out_o, stream_last_o) is shown and
// pop_i takes it. One beat per run packet or raw pixel; header on the first.
// A write on cfg_valid_i/cfg_data_i sets the red/blue swap (reset: on).
//
// A pixel is taken per cycle while packets grow and full_o is low. A closing
// packet becomes a command in a 4-deep queue; the back end expands it at one
// beat per cycle while the result queue has room (raw pixels come from a
// two-bank buffer RAM with registered read) and registers each beat before
// the result queue. Up to two packets per pixel: the second waits in a hold
// register that holds full_o high. Input stalls while the bank to be filled
// is still being drained, so raw packets longer than one pixel sustain about
// one pixel per cycle when the sink pops every cycle. A stalled sink fills
// the 4-beat result queue, then the command queue, then holds full_o high.
// Reset empties all queues and the open packet; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tga_rle_pixel_encoder
  import trle_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [31:0] pixel_in_i,
  input  logic        image_end_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        header_valid_o,
  output logic [7:0]  header_byte_o,
  output logic [31:0] pixel_out_o,
  output logic        stream_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_PACKET) + 1;

  cmd_t                         cmd_in, cmd_out;
  logic                         cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
  logic [31:0]                  ram_wdata, ram_rdata;
  bank_free_t                   bank_free;
  logic                         out_push, out_full;
  item_t                        out_item, out_head;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  assign cfg_ready_o = 1'b1;

  // Front end: classify pixels and fill the raw buffer
  trle_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .pixel_in_i  (pixel_in_i),
    .image_end_i (image_end_i),
    .full_o      (full_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .bank_free_i (bank_free)
  );

  // Packet command queue
  trle_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  // Two-bank raw pixel buffer
  trle_ram #(
    .WIDTH(32),
    .DEPTH(2 ** ADDR_W)
  ) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back end: expand commands into beats
  trle_back #(
    .MAX_PACKET(MAX_PACKET)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .bank_free_o (bank_free),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_item_o  (out_item)
  );

  // Result queue
  trle_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_head),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  assign header_valid_o = out_head.header_valid;
  assign header_byte_o  = out_head.header_byte;
  assign pixel_out_o    = out_head.pixel_out;
  assign stream_last_o  = out_head.stream_last;

  // Queue counts stay within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_count <= ($bits(cmd_count))'(CMD_DEPTH))
    else $error("tga_rle_pixel_encoder: command queue overfilled");

  // No beat is pushed into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("tga_rle_pixel_encoder: result beat dropped");

  // The buffer is never written and drained at the same bank in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && bank_free.valid) |-> (ram_waddr[ADDR_W-1] != bank_free.bank))
    else $error("tga_rle_pixel_encoder: write into bank being drained");

endmodule

@@ hdl/trle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/trle_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_fifo
// Small register queue with fill count, used for commands and results.
// ----------------------------------------------------------------------------
module trle_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/trle_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_front
// Accepts pixels, tracks the open packet and issues packet commands.
// Raw pixels go to a two-bank buffer so the back end can drain one bank
// while the next raw packet fills the other.
// ----------------------------------------------------------------------------
module trle_front
  import trle_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [31:0]                   pixel_in_i,
  input  logic                          image_end_i,
  output logic                          full_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_data_i,
  output logic                          cmd_push_o,
  output cmd_t                          cmd_o,
  input  logic                          cmd_full_i,
  output logic                          ram_we_o,
  output logic [$clog2(MAX_PACKET):0]   ram_waddr_o,
  output logic [31:0]                   ram_wdata_o,
  input  bank_free_t                    bank_free_i
);

  localparam int unsigned IDX_W = $clog2(MAX_PACKET);

  logic        swap_q;
  logic [7:0]  pend_q, pend_d;
  logic        run_q, run_d;
  logic [31:0] prev_q, prev_d;
  logic        bank_q, bank_d;
  logic [1:0]  busy_q, busy_d, busy_set;
  logic        hold_v_q, hold_v_d;
  cmd_t        hold_q;

  logic        accept, raw_full;
  logic [31:0] pix;
  logic        wr;
  logic [7:0]  widx;
  logic        wbank;
  cmd_t        cmd_a, cmd_b;
  logic        cmd_a_v, cmd_b_v;

  // Stall on a held command, full queue, busy bank, or full raw packet with the other bank busy
  assign raw_full = !run_q && (pend_q == 8'(MAX_PACKET));
  assign full_o   = hold_v_q || cmd_full_i || busy_q[bank_q] ||
                    (raw_full && busy_q[!bank_q]);
  assign accept   = push_i && !full_o;

  // Classify the pixel and update the open packet
  always_comb begin
    pix      = swap_q ? {pixel_in_i[31:24], pixel_in_i[7:0],
                         pixel_in_i[15:8], pixel_in_i[23:16]} : pixel_in_i;
    pend_d   = pend_q;
    run_d    = run_q;
    prev_d   = prev_q;
    bank_d   = bank_q;
    wr       = 1'b0;
    widx     = '0;
    wbank    = bank_q;
    cmd_a    = '0;
    cmd_a_v  = 1'b0;
    cmd_b    = '0;
    cmd_b_v  = 1'b0;
    busy_set = '0;

    if (accept) begin
      if (pend_q == '0) begin
        wr = 1'b1; widx = '0; wbank = bank_q;
        pend_d = 8'd1; run_d = 1'b0; prev_d = pix;
      end else if (run_q) begin
        if (pix == prev_q && pend_q < 8'(MAX_PACKET)) begin
          pend_d = pend_q + 8'd1;
        end else begin
          cmd_a_v = 1'b1;
          cmd_a.is_run = 1'b1;
          cmd_a.count  = pend_q;
          cmd_a.pixel  = prev_q;
          wr = 1'b1; widx = '0; wbank = bank_q;
          pend_d = 8'd1; run_d = 1'b0; prev_d = pix;
        end
      end else if (pix == prev_q) begin
        // Pixels before the repeat close as a raw packet
        if (pend_q > 8'd1) begin
          cmd_a_v = 1'b1;
          cmd_a.count = pend_q - 8'd1;
          cmd_a.bank  = bank_q;
          busy_set[bank_q] = 1'b1;
          bank_d = !bank_q;
        end
        run_d  = 1'b1;
        pend_d = 8'd2;
      end else if (pend_q < 8'(MAX_PACKET)) begin
        wr = 1'b1; widx = pend_q; wbank = bank_q;
        pend_d = pend_q + 8'd1;
        prev_d = pix;
      end else begin
        // Full raw packet: emit it and start over in the other bank
        cmd_a_v = 1'b1;
        cmd_a.count = pend_q;
        cmd_a.bank  = bank_q;
        busy_set[bank_q] = 1'b1;
        bank_d = !bank_q;
        wr = 1'b1; widx = '0; wbank = !bank_q;
        pend_d = 8'd1; run_d = 1'b0; prev_d = pix;
      end

      // Flush the open packet at image end
      if (image_end_i) begin
        cmd_b_v = 1'b1;
        cmd_b.last  = 1'b1;
        cmd_b.count = pend_d;
        if (run_d) begin
          cmd_b.is_run = 1'b1;
          cmd_b.pixel  = prev_d;
        end else begin
          cmd_b.bank = bank_d;
          busy_set[bank_d] = 1'b1;
          bank_d = !bank_d;
        end
        pend_d = '0;
        run_d  = 1'b0;
        prev_d = '0;
      end
    end
  end

  assign ram_we_o    = wr;
  assign ram_waddr_o = {wbank, widx[IDX_W-1:0]};
  assign ram_wdata_o = pix;

  // Command queue feed: first command now, a second one from the hold register once the queue has room
  always_comb begin
    hold_v_d   = hold_v_q;
    cmd_push_o = 1'b0;
    cmd_o      = cmd_a_v ? cmd_a : cmd_b;
    if (hold_v_q) begin
      cmd_o = hold_q;
      if (!cmd_full_i) begin
        cmd_push_o = 1'b1;
        hold_v_d   = 1'b0;
      end
    end else if (cmd_a_v || cmd_b_v) begin
      cmd_push_o = 1'b1;
      hold_v_d   = cmd_a_v && cmd_b_v;
    end
  end

  // Mark banks busy on issue, release when drained
  always_comb begin
    busy_d = busy_q | busy_set;
    if (bank_free_i.valid) begin
      busy_d[bank_free_i.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q   <= 1'b1;
      pend_q   <= '0;
      run_q    <= 1'b0;
      prev_q   <= '0;
      bank_q   <= 1'b0;
      busy_q   <= '0;
      hold_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        swap_q <= cfg_data_i;
      end
      pend_q   <= pend_d;
      run_q    <= run_d;
      prev_q   <= prev_d;
      bank_q   <= bank_d;
      busy_q   <= busy_d;
      hold_v_q <= hold_v_d;
    end
  end

  // Hold the flush command behind the first one
  always_ff @(posedge clk_i) begin
    if (accept && cmd_a_v && cmd_b_v) begin
      hold_q <= cmd_b;
    end
  end

endmodule

@@ hdl/trle_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_back
// Expands packet commands into result beats: one beat per run packet,
// one beat per buffered pixel of a raw packet, read from the buffer RAM.
// ----------------------------------------------------------------------------
module trle_back
  import trle_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmd_t                            cmd_i,
  input  logic                            cmd_empty_i,
  output logic                            cmd_pop_o,
  output logic [$clog2(MAX_PACKET):0]     ram_raddr_o,
  input  logic [31:0]                     ram_rdata_i,
  output bank_free_t                      bank_free_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count_i,
  output logic                            out_push_o,
  output item_t                           out_item_o
);

  localparam int unsigned IDX_W = $clog2(MAX_PACKET);
  localparam int unsigned OCW   = $clog2(OUT_DEPTH+1);

  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e      state_q;
  cmd_t        cmd_q;
  logic [7:0]  idx_q;
  logic        s1_v_q, s1_ram_q;
  item_t       s1_q;

  logic        room, issue, last_item;
  logic [7:0]  cnt_m1;
  logic [7:0]  hdr;

  // Room for one more beat in the result queue, counting the one in flight
  assign room      = (OCW'(out_count_i + OCW'(s1_v_q)) < OCW'(OUT_DEPTH));
  assign issue     = (state_q == ST_EMIT) && room;
  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i;
  assign cnt_m1    = cmd_q.count - 8'd1;
  // A run packet ends after its single beat
  assign last_item = cmd_q.is_run || (idx_q == cnt_m1);
  assign hdr       = cmd_q.is_run ? (HDR_RUN_FLAG | {1'b0, cnt_m1[6:0] & HDR_CNT_MASK})
                                  : {1'b0, cnt_m1[6:0] & HDR_CNT_MASK};

  assign ram_raddr_o       = {cmd_q.bank, idx_q[IDX_W-1:0]};
  assign bank_free_o.valid = issue && last_item && !cmd_q.is_run;
  assign bank_free_o.bank  = cmd_q.bank;

  // Second stage: merge RAM data into the beat
  always_comb begin
    out_push_o = s1_v_q;
    out_item_o = s1_q;
    if (s1_ram_q) begin
      out_item_o.pixel_out = ram_rdata_i;
    end
  end

  // Sequence the beats of one packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      s1_v_q  <= 1'b0;
    end else begin
      s1_v_q <= issue;
      case (state_q)
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            state_q <= ST_EMIT;
            idx_q   <= '0;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            idx_q <= idx_q + 8'd1;
            if (last_item) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Command and beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (issue) begin
      s1_ram_q             <= !cmd_q.is_run;
      s1_q.header_valid    <= (idx_q == '0);
      s1_q.header_byte     <= (idx_q == '0) ? hdr : 8'd0;
      s1_q.pixel_out       <= cmd_q.pixel;
      s1_q.stream_last     <= cmd_q.last && last_item;
    end
  end

  // A beat never lands in a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (out_count_i != OCW'(OUT_DEPTH)))
    else $error("trle_back: beat pushed into full result queue");

  // A loaded packet always has pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cmd_q.count != 8'd0))
    else $error("trle_back: empty packet command");

  // The beat index stays inside the packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (idx_q < cmd_q.count))
    else $error("trle_back: beat index past packet end");

  // A run packet spans exactly one beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && cmd_q.is_run) |-> last_item)
    else $error("trle_back: run packet with more than one beat");

endmodule

@@ tb/tga_rle_pixel_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder_tb
// Self-checking bench for the TGA run-length pixel encoder.
//
// Pixels are pushed into the input queue side and every popped beat is
// compared field by field with the oldest beat that a local packet encoder
// model predicted. A short table of hand-picked pixels comes first. Random
// images follow: runs, raw stretches, full packets, a palette that produces
// accidental repeats, and a swap change in the middle of an image. Both
// sides idle in random bursts. One phase holds the sink for a long stretch
// so that the encoder backs up and raises full.
// ----------------------------------------------------------------------------
module tga_rle_pixel_encoder_tb;
  import trle_pkg::*;

  localparam int unsigned MAX_PACKET = 32;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned SINK_HOLD_CYCLES = 80;

  // One pixel to push
  typedef struct packed {
    logic [31:0] px;
    logic        last;
  } pix_req_t;

  // One row of the directed table; n_beats/hdr are checked when typed is set
  typedef struct packed {
    logic [31:0] px;
    logic        last;
    logic        typed;
    logic [5:0]  n_beats;
    logic [7:0]  hdr;
  } dir_row_t;

  localparam int N_DIR = 17;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [31:0] pixel_in_i = '0;
  logic        image_end_i = 1'b0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic        header_valid_o;
  logic [7:0]  header_byte_o;
  logic [31:0] pixel_out_o;
  logic        stream_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  // Encoder model state
  logic [31:0] open_px [MAX_PACKET];
  logic [7:0]  open_cnt = '0;
  logic        open_is_run = 1'b0;
  logic [31:0] last_px = '0;
  logic        swap_rb = 1'b1;

  item_t    packet_beats_q [$];
  pix_req_t pix_q [$];
  int       err_cnt = 0;
  bit       quiet = 1'b0;
  bit       hold_sink = 1'b0;

  dir_row_t dir_rows [N_DIR] = '{
    '{32'h11223344, 1'b1, 1'b1, 6'd1, 8'h00},
    '{32'hFFFFFFFF, 1'b0, 1'b1, 6'd0, 8'h00},
    '{32'hFFFFFFFF, 1'b1, 1'b1, 6'd1, HDR_RUN_FLAG | 8'd1},
    '{32'h00000000, 1'b0, 1'b1, 6'd0, 8'h00},
    '{32'h00000001, 1'b0, 1'b0, 6'd0, 8'h00},
    '{32'h00010000, 1'b0, 1'b0, 6'd0, 8'h00},
    '{32'h00010000, 1'b0, 1'b1, 6'd2, 8'h01},
    '{32'h00010000, 1'b0, 1'b0, 6'd0, 8'h00},
    '{32'hA5A5A5A5, 1'b0, 1'b1, 6'd1, HDR_RUN_FLAG | 8'd2},
    '{32'h5A5A5A5A, 1'b1, 1'b1, 6'd2, 8'h01},
    '{32'hDEADBEEF, 1'b0, 1'b0, 6'd0, 8'h00},
    '{32'hDEADBEEF, 1'b0, 1'b0, 6'd0, 8'h00},
    '{32'hCAFEF00D, 1'b1, 1'b1, 6'd2, HDR_RUN_FLAG | 8'd1},
    '{32'h80000000, 1'b1, 1'b1, 6'd1, 8'h00},
    '{32'h7FFFFFFF, 1'b0, 1'b0, 6'd0, 8'h00},
    '{32'h7FFFFFFF, 1'b0, 1'b0, 6'd0, 8'h00},
    '{32'h7FFFFFFF, 1'b1, 1'b1, 6'd1, HDR_RUN_FLAG | 8'd2}
  };

  tga_rle_pixel_encoder #(
    .MAX_PACKET(MAX_PACKET)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .pixel_in_i    (pixel_in_i),
    .image_end_i   (image_end_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .header_valid_o(header_valid_o),
    .header_byte_o (header_byte_o),
    .pixel_out_o   (pixel_out_o),
    .stream_last_o (stream_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Packet encoder model
  // ------------------------------------------------------------------------
  task automatic open_packet(input logic [31:0] px);
    open_px[0] = px;
    open_cnt = 8'd1;
    open_is_run = 1'b0;
    last_px = px;
  endtask

  task automatic close_run(ref item_t beats [$]);
    item_t b;
    b.header_valid = 1'b1;
    b.header_byte = HDR_RUN_FLAG | {1'b0, HDR_CNT_MASK & 7'(open_cnt - 8'd1)};
    b.pixel_out = last_px;
    b.stream_last = 1'b0;
    beats.push_back(b);
  endtask

  task automatic close_raw(ref item_t beats [$], input int n);
    item_t b;
    for (int i = 0; i < n; i++) begin
      b.header_valid = (i == 0);
      b.header_byte = (i == 0) ? {1'b0, HDR_CNT_MASK & 7'(n - 1)} : 8'h00;
      b.pixel_out = open_px[i];
      b.stream_last = 1'b0;
      beats.push_back(b);
    end
  endtask

  // Advance the model by one pixel and queue the beats it releases
  task automatic encode_pixel(input logic [31:0] px_in, input logic img_end,
                              output int n_beats, output logic [7:0] first_hdr);
    logic [31:0] px;
    item_t       beats [$];
    px = swap_rb ? {px_in[31:24], px_in[7:0], px_in[15:8], px_in[23:16]} : px_in;
    if (open_cnt == 0) begin
      open_packet(px);
    end else if (open_is_run) begin
      if (px == last_px && open_cnt < MAX_PACKET) begin
        open_cnt++;
      end else begin
        close_run(beats);
        open_packet(px);
      end
    end else if (px == last_px) begin
      // repeat ends the raw stretch before it; the pair starts a run
      close_raw(beats, open_cnt - 1);
      open_is_run = 1'b1;
      open_cnt = 8'd2;
    end else if (open_cnt < MAX_PACKET) begin
      open_px[open_cnt] = px;
      open_cnt++;
      last_px = px;
    end else begin
      close_raw(beats, open_cnt);
      open_packet(px);
    end
    // flush everything on the image end marker
    if (img_end) begin
      if (open_is_run) begin
        close_run(beats);
      end else begin
        close_raw(beats, open_cnt);
      end
      if (beats.size() > 0) begin
        beats[beats.size() - 1].stream_last = 1'b1;
      end
      open_cnt = '0;
      open_is_run = 1'b0;
      last_px = '0;
    end
    n_beats = beats.size();
    first_hdr = (n_beats > 0) ? beats[0].header_byte : 8'h00;
    foreach (beats[i]) begin
      packet_beats_q.push_back(beats[i]);
    end
  endtask

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------
  // Offer one pixel, hold it until taken, then update the model
  task automatic push_pixel(input logic [31:0] px, input logic img_end,
                            output int n_beats, output logic [7:0] first_hdr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    push_i = 1'b1;
    pixel_in_i = px;
    image_end_i = img_end;
    do @(posedge clk_i); while (full_o);
    encode_pixel(px, img_end, n_beats, first_hdr);
    @(negedge clk_i);
  endtask

  task automatic push_all;
    int         n;
    logic [7:0] h;
    while (pix_q.size() > 0) begin
      push_pixel(pix_q[0].px, pix_q[0].last, n, h);
      void'(pix_q.pop_front());
    end
    push_i = 1'b0;
  endtask

  // Wait for every predicted beat, then let the back end settle
  task automatic drain;
    push_i = 1'b0;
    while (packet_beats_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_swap(input logic val);
    cfg_valid_i = 1'b1;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    swap_rb = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Append one image of mixed runs, raw stretches and palette pixels
  task automatic build_image(input int target, input bit long_ok, input bit close_img);
    logic [31:0] pal [4];
    logic [31:0] px;
    int          len;
    int          made;
    int          kind;
    foreach (pal[i]) pal[i] = $urandom;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 9);
      len = (long_ok && $urandom_range(0, 3) == 0) ? $urandom_range(30, 36)
                                                    : $urandom_range(1, 5);
      if (kind < 4) begin
        px = $urandom;
        for (int j = 0; j < len; j++) begin
          // break the run now and then with one flipped bit
          if ($urandom_range(0, 15) == 0) begin
            pix_q.push_back({px ^ (32'd1 << $urandom_range(0, 31)), 1'b0});
          end else begin
            pix_q.push_back({px, 1'b0});
          end
        end
      end else if (kind < 8) begin
        for (int j = 0; j < len; j++) pix_q.push_back({32'($urandom), 1'b0});
      end else begin
        for (int j = 0; j < len; j++) pix_q.push_back({pal[$urandom_range(0, 3)], 1'b0});
      end
      made += len;
    end
    if (close_img) begin
      pix_q[pix_q.size() - 1].last = 1'b1;
    end
  endtask

  // ------------------------------------------------------------------------
  // Result side: random pop gaps, one long hold on request
  // ------------------------------------------------------------------------
  initial begin
    int    idle_left;
    item_t want;
    idle_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        pop_i = 1'b0;
        for (int c = 0; c < SINK_HOLD_CYCLES; c++) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      if (!quiet && idle_left == 0 && $urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(1, 6);
      end
      if (idle_left > 0) begin
        pop_i = 1'b0;
        idle_left--;
      end else begin
        pop_i = 1'b1;
      end
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        if (packet_beats_q.size() == 0) begin
          $error("beat with no prediction: hv=%0b hdr=%0h px=%0h last=%0b",
                 header_valid_o, header_byte_o, pixel_out_o, stream_last_o);
          err_cnt++;
        end else begin
          want = packet_beats_q.pop_front();
          if (header_valid_o !== want.header_valid) begin
            $error("header_valid: expected %0b, got %0b", want.header_valid, header_valid_o);
            err_cnt++;
          end
          if (header_byte_o !== want.header_byte) begin
            $error("header_byte: expected %0h, got %0h", want.header_byte, header_byte_o);
            err_cnt++;
          end
          if (pixel_out_o !== want.pixel_out) begin
            $error("pixel_out: expected %0h, got %0h", want.pixel_out, pixel_out_o);
            err_cnt++;
          end
          if (stream_last_o !== want.stream_last) begin
            $error("stream_last: expected %0b, got %0b", want.stream_last, stream_last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    int          n;
    logic [7:0]  h;
    logic [31:0] px;
    logic [31:0] tail_px;
    foreach (open_px[i]) open_px[i] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table, swap on from reset
    for (int r = 0; r < N_DIR; r++) begin
      push_pixel(dir_rows[r].px, dir_rows[r].last, n, h);
      if (dir_rows[r].typed && (n != dir_rows[r].n_beats || h !== dir_rows[r].hdr)) begin
        $error("row %0d: expected %0d beats hdr %0h, model gives %0d beats hdr %0h",
               r, dir_rows[r].n_beats, dir_rows[r].hdr, n, h);
        err_cnt++;
      end
    end
    drain();

    // Short random images, swap off
    write_swap(1'b0);
    for (int i = 0; i < 2; i++) build_image($urandom_range(3, 6), 1'b0, 1'b1);
    push_all();
    drain();

    // Full run, full raw packet, raw stretch ending in a repeat; leave open
    write_swap(1'b1);
    px = $urandom;
    for (int j = 0; j < 33; j++) pix_q.push_back({px, 1'b0});
    for (int j = 0; j < 33; j++) pix_q.push_back({32'($urandom), 1'b0});
    for (int j = 0; j < 3; j++) pix_q.push_back({32'($urandom), 1'b0});
    tail_px = pix_q[pix_q.size() - 1].px;
    pix_q.push_back({tail_px, 1'b0});
    pix_q.push_back({32'($urandom), 1'b0});
    tail_px = pix_q[pix_q.size() - 1].px;
    push_all();
    drain();

    // Swap flips mid-image; sink stalls long while small images pour in
    write_swap(1'b0);
    pix_q.push_back({tail_px, 1'b0});
    pix_q.push_back({tail_px, 1'b1});
    for (int i = 0; i < 6; i++) build_image($urandom_range(1, 2), 1'b0, 1'b1);
    hold_sink = 1'b1;
    push_all();
    drain();

    // Back to swap on, no idling on either side
    write_swap(1'b1);
    quiet = 1'b1;
    for (int i = 0; i < 2; i++) build_image($urandom_range(3, 6), 1'b0, 1'b1);
    push_all();
    drain();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
